/* rtl/core/ecal_pkg.sv */
// Shared widths, register map, reset values and control types for the EMG envelope block.
package ecal_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int COEF_FRAC_BITS = 24;

  localparam int BASE_FRAC = 8;
  localparam int CNT_W     = 16;
  localparam int COEF_W    = COEF_FRAC_BITS;
  localparam int LEVEL_W   = SAMPLE_BITS + BASE_FRAC;
  localparam int FILT_W    = SAMPLE_BITS + COEF_FRAC_BITS;
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int NUM_W     = SUM_W + BASE_FRAC + 1;
  localparam int XS_W      = LEVEL_W + 1;
  localparam int LO_W      = (FILT_W + 1) / 2;
  localparam int HI_W      = FILT_W - LO_W;
  localparam int PROD_W    = COEF_W + LO_W;
  localparam int ACC_W     = COEF_W + FILT_W;
  localparam int ENV_SHIFT = COEF_FRAC_BITS - BASE_FRAC;

  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * LEVEL_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_CALIB_COUNT   = 4'h0;
  localparam logic [APB_ADDR_W-1:0] ADDR_FEEDBACK_COEF = 4'h4;
  localparam logic [APB_ADDR_W-1:0] ADDR_INPUT_COEF    = 4'h8;

  localparam logic [CNT_W-1:0]  CALIB_COUNT_RST   = 16'd10000;
  localparam logic [COEF_W-1:0] FEEDBACK_COEF_RST = 24'd16672132;
  localparam logic [COEF_W-1:0] INPUT_COEF_RST    = 24'd52542;

  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_RUN   = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  calib_count;
    logic [COEF_W-1:0] feedback_coef;
    logic [COEF_W-1:0] input_coef;
  } ecal_cfg_t;

  typedef struct packed {
    logic load;
    logic cal_acc;
    logic div_start;
    logic base_load;
    logic x_abs;
    logic mul_lo;
    logic mul_hi;
    logic mul_acc;
    logic sel_t2;
    logic t1_save;
    logic t2_save;
    logic filt_update;
    logic out_load;
  } ecal_cmd_t;

  typedef struct packed {
    logic cal_complete;
    logic div_done;
  } ecal_status_t;

endpackage

/* rtl/core/ecal_regs.sv */
// Configuration register file behind the APB-style port.
module ecal_regs
  import ecal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output ecal_cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calib_count   <= CALIB_COUNT_RST;
      cfg.feedback_coef <= FEEDBACK_COEF_RST;
      cfg.input_coef    <= INPUT_COEF_RST;
    end else if (wr_en) begin
      if (paddr == ADDR_CALIB_COUNT) begin
        cfg.calib_count <= pwdata[CNT_W-1:0];
      end
      if (paddr == ADDR_FEEDBACK_COEF) begin
        cfg.feedback_coef <= pwdata[COEF_W-1:0];
      end
      if (paddr == ADDR_INPUT_COEF) begin
        cfg.input_coef <= pwdata[COEF_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CALIB_COUNT) begin
      prdata = APB_DATA_W'(cfg.calib_count);
    end else if (paddr == ADDR_FEEDBACK_COEF) begin
      prdata = APB_DATA_W'(cfg.feedback_coef);
    end else if (paddr == ADDR_INPUT_COEF) begin
      prdata = APB_DATA_W'(cfg.input_coef);
    end
  end

endmodule

/* rtl/core/ecal_div.sv */
// Restoring divider, one quotient bit per cycle, for the baseline mean.
module ecal_div
  import ecal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem[CNT_W-1:0], quotient[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/ecal_dp.sv */
// Datapath: calibration sum, baseline, filter multiply-accumulate and result register.
module ecal_dp
  import ecal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ecal_cmd_t             cmd,
  input  ecal_cfg_t             cfg,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output ecal_status_t          status,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [ACC_W:0]    HALF1 = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [ACC_W:0]    HALF2 = (ACC_W + 1)'(1) << (BASE_FRAC - 1);
  localparam logic [FILT_W:0]   HALFE = (FILT_W + 1)'(1) << (ENV_SHIFT - 1);
  localparam logic [FILT_W-1:0] FILT_MAX  = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SUM_W-1:0]       calib_sum;
  logic [CNT_W-1:0]       calib_seen;
  logic [CNT_W-1:0]       n_r;
  logic                   complete_r;
  logic [LEVEL_W-1:0]     baseline_level;
  logic                   have_baseline;
  logic                   done_r;
  logic [FILT_W-1:0]      prev_filtered;
  logic [LEVEL_W-1:0]     prev_rectified;
  logic [LEVEL_W-1:0]     x_r;
  logic [XS_W-1:0]        xs_r;
  logic [PROD_W-1:0]      prod_r;
  logic [ACC_W-1:0]       acc_r;
  logic [FILT_W-1:0]      t1_r;
  logic [FILT_W-1:0]      t2_r;
  logic [LEVEL_W-1:0]     env_out;
  logic [LEVEL_W-1:0]     base_out;
  logic                   valid_out;
  logic                   done_out;

  logic [SUM_W-1:0]   sum_new;
  logic [CNT_W:0]     n_new;
  logic [CNT_W:0]     target;
  logic [NUM_W-1:0]   dividend;
  logic [NUM_W-1:0]   quotient;
  logic               div_done;
  logic [LEVEL_W-1:0] s8;
  logic [COEF_W-1:0]  mul_a;
  logic [FILT_W-1:0]  mul_b;
  logic [LO_W-1:0]    b_lo;
  logic [LO_W-1:0]    b_hi;
  logic [ACC_W:0]     rnd1;
  logic [ACC_W:0]     rnd2;
  logic [FILT_W:0]    y_sum;
  logic [FILT_W:0]    env_sum;
  logic [FILT_W:0]    env_sh;

  assign sum_new  = calib_sum + SUM_W'(sample_r);
  assign n_new    = (CNT_W + 1)'(calib_seen) + 1'b1;
  assign target   = (cfg.calib_count == '0) ? (CNT_W + 1)'(1) : (CNT_W + 1)'(cfg.calib_count);
  assign dividend = NUM_W'({calib_sum, {BASE_FRAC{1'b0}}}) + NUM_W'(n_r >> 1);
  assign s8       = {sample_r, {BASE_FRAC{1'b0}}};

  assign mul_a = cmd.sel_t2 ? cfg.input_coef : cfg.feedback_coef;
  assign mul_b = cmd.sel_t2 ? FILT_W'(xs_r) : prev_filtered;
  assign b_lo  = mul_b[LO_W-1:0];
  assign b_hi  = LO_W'(mul_b[FILT_W-1:LO_W]);

  assign rnd1    = ((ACC_W + 1)'(acc_r) + HALF1) >> COEF_FRAC_BITS;
  assign rnd2    = ((ACC_W + 1)'(acc_r) + HALF2) >> BASE_FRAC;
  assign y_sum   = (FILT_W + 1)'(t1_r) + (FILT_W + 1)'(t2_r);
  assign env_sum = (FILT_W + 1)'(prev_filtered) + HALFE;
  assign env_sh  = env_sum >> ENV_SHIFT;

  assign status.cal_complete = complete_r;
  assign status.div_done     = div_done;

  ecal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (n_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_sum      <= '0;
      calib_seen     <= '0;
      baseline_level <= '0;
      have_baseline  <= 1'b0;
      prev_filtered  <= '0;
      prev_rectified <= '0;
      complete_r     <= 1'b0;
      done_r         <= 1'b0;
    end else begin
      if (cmd.load) begin
        done_r <= 1'b0;
      end
      if (cmd.cal_acc) begin
        calib_sum  <= sum_new;
        calib_seen <= n_new[CNT_W-1:0];
        n_r        <= n_new[CNT_W-1:0];
        complete_r <= n_new >= target;
      end
      if (cmd.base_load) begin
        baseline_level <= (|quotient[NUM_W-1:LEVEL_W]) ? LEVEL_MAX
                                                       : quotient[LEVEL_W-1:0];
        have_baseline  <= 1'b1;
        calib_sum      <= '0;
        calib_seen     <= '0;
        complete_r     <= 1'b0;
        done_r         <= 1'b1;
      end
      if (cmd.filt_update) begin
        prev_filtered  <= y_sum[FILT_W] ? FILT_MAX : y_sum[FILT_W-1:0];
        prev_rectified <= x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (cmd.x_abs) begin
      x_r <= (s8 >= baseline_level) ? s8 - baseline_level : baseline_level - s8;
    end
    if (cmd.mul_lo) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(b_lo);
    end
    if (cmd.mul_hi) begin
      acc_r  <= ACC_W'(prod_r);
      prod_r <= PROD_W'(mul_a) * PROD_W'(b_hi);
    end
    if (cmd.mul_acc) begin
      acc_r <= acc_r + ACC_W'({prod_r, {LO_W{1'b0}}});
    end
    if (cmd.t1_save) begin
      t1_r <= (|rnd1[ACC_W:FILT_W]) ? FILT_MAX : rnd1[FILT_W-1:0];
      xs_r <= XS_W'(x_r) + XS_W'(prev_rectified);
    end
    if (cmd.t2_save) begin
      t2_r <= (|rnd2[ACC_W:FILT_W]) ? FILT_MAX : rnd2[FILT_W-1:0];
    end
    if (cmd.out_load) begin
      env_out   <= (|env_sh[FILT_W:LEVEL_W]) ? LEVEL_MAX : env_sh[LEVEL_W-1:0];
      base_out  <= baseline_level;
      valid_out <= have_baseline;
      done_out  <= done_r;
    end
  end

  assign m_tdata = OUT_DATA_W'({done_out, valid_out, base_out, env_out});

endmodule

/* rtl/core/ecal_ctrl.sv */
// Controller state machine sequencing calibration, division and filter steps.
module ecal_ctrl
  import ecal_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         in_kind,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  ecal_status_t status,
  output ecal_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAL, ST_DECIDE, ST_DIV_WAIT, ST_BASE, ST_XABS,
    ST_M1A, ST_M1B, ST_M1C, ST_T1, ST_M2A, ST_M2B, ST_M2C, ST_T2,
    ST_FILT, ST_FIN
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.sel_t2 = (state == ST_M2A) || (state == ST_M2B);
    unique case (state)
      ST_CAL:    cmd.cal_acc     = 1'b1;
      ST_DECIDE: cmd.div_start   = status.cal_complete;
      ST_BASE:   cmd.base_load   = 1'b1;
      ST_XABS:   cmd.x_abs       = 1'b1;
      ST_M1A:    cmd.mul_lo      = 1'b1;
      ST_M1B:    cmd.mul_hi      = 1'b1;
      ST_M1C:    cmd.mul_acc     = 1'b1;
      ST_T1:     cmd.t1_save     = 1'b1;
      ST_M2A:    cmd.mul_lo      = 1'b1;
      ST_M2B:    cmd.mul_hi      = 1'b1;
      ST_M2C:    cmd.mul_acc     = 1'b1;
      ST_T2:     cmd.t2_save     = 1'b1;
      ST_FILT:   cmd.filt_update = 1'b1;
      ST_FIN:    cmd.out_load    = out_free;
      default:   cmd.load        = accept;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (in_kind == KIND_RUN) ? ST_XABS : ST_CAL;
          end
        end
        ST_CAL:      state <= ST_DECIDE;
        ST_DECIDE:   state <= status.cal_complete ? ST_DIV_WAIT : ST_FIN;
        ST_DIV_WAIT: begin
          if (status.div_done) begin
            state <= ST_BASE;
          end
        end
        ST_BASE:     state <= ST_FIN;
        ST_XABS:     state <= ST_M1A;
        ST_M1A:      state <= ST_M1B;
        ST_M1B:      state <= ST_M1C;
        ST_M1C:      state <= ST_T1;
        ST_T1:       state <= ST_M2A;
        ST_M2A:      state <= ST_M2B;
        ST_M2B:      state <= ST_M2C;
        ST_M2C:      state <= ST_T2;
        ST_T2:       state <= ST_FILT;
        ST_FILT:     state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:     state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/emg_envelope_with_baseline_calib.sv */
// Top level: EMG baseline calibration and rectified low-pass envelope.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready   | tdata: sample; tuser: cmd
//  m_*     | out | m_tvalid / m_tready   | tdata: envelope, baseline, valid, done
//  apb     | in  | psel & penable        | calib_count, feedback_coef, input_coef
//
//  Run word: the result is set by two split 24x17 multiplies.
//  Calibration word: when it completes, the baseline comes from a 35-step restoring divider.
//  A new word is taken once the previous one sits in the output register.
//  rst is synchronous, clears sums, baseline, filter state and handshakes.
//  A held result stalls the next word only at its final step.
module emg_envelope_with_baseline_calib
  import ecal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] sample, rest zero
  input  logic [0:0]            s_tuser,   // [0] cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [17:0] envelope, [35:18] baseline,
                                           // [36] baseline_valid, [37] calib_done
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ecal_cfg_t    cfg;
  ecal_cmd_t    cmd;
  ecal_status_t status;

  ecal_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ecal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_kind  (s_tuser[0]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ecal_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .status  (status),
    .m_tdata (m_tdata)
  );

endmodule

/* verif/ecal_envelope_checker.sv */
`timescale 1ns / 1ps
// Checker for the EMG envelope block: tracks both stream channels and the register port.
module ecal_envelope_checker
  import ecal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] sample, rest zero
  input  logic [0:0]            s_tuser,   // [0] cmd
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [17:0] envelope, [35:18] baseline,
                                           // [36] baseline_valid, [37] calib_done
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    outstanding
);

  localparam logic [63:0] LEVEL_TOP = (64'd1 << LEVEL_W) - 64'd1;
  localparam logic [63:0] FILT_TOP  = (64'd1 << FILT_W) - 64'd1;

  typedef struct packed {
    logic [LEVEL_W-1:0] envelope;
    logic [LEVEL_W-1:0] baseline;
    logic               baseline_valid;
    logic               calib_done;
  } env_word_t;

  ecal_cfg_t          regs;
  logic [SUM_W-1:0]   cal_sum;
  logic [CNT_W-1:0]   cal_seen;
  logic [LEVEL_W-1:0] base_lvl;
  logic               base_ok;
  logic [FILT_W-1:0]  filt_acc;
  logic [LEVEL_W-1:0] last_rect;
  env_word_t          expected_q[$];

  task automatic step_envelope(input logic kind, input logic [SAMPLE_BITS-1:0] smp,
                               output env_word_t w);
    logic [63:0] n, target, mean, s8, x, t1, t2, y, env;
    w.calib_done = 1'b0;
    if (kind == KIND_CALIB) begin
      n = 64'(cal_seen) + 64'd1;
      target = (regs.calib_count == '0) ? 64'd1 : 64'(regs.calib_count);
      cal_sum = cal_sum + smp;
      if (n >= target) begin
        mean = ((64'(cal_sum) << BASE_FRAC) + (n >> 1)) / n;
        base_lvl = (mean > LEVEL_TOP) ? LEVEL_TOP[LEVEL_W-1:0] : mean[LEVEL_W-1:0];
        base_ok = 1'b1;
        cal_sum = '0;
        cal_seen = '0;
        w.calib_done = 1'b1;
      end else begin
        cal_seen = n[CNT_W-1:0];
      end
    end else begin
      s8 = 64'(smp) << BASE_FRAC;
      x = (s8 >= 64'(base_lvl)) ? s8 - 64'(base_lvl) : 64'(base_lvl) - s8;
      t1 = (64'(regs.feedback_coef) * 64'(filt_acc) + (64'd1 << (COEF_FRAC_BITS - 1)))
           >> COEF_FRAC_BITS;
      t2 = (64'(regs.input_coef) * (x + 64'(last_rect)) + (64'd1 << (BASE_FRAC - 1)))
           >> BASE_FRAC;
      if (t1 > FILT_TOP) t1 = FILT_TOP;
      if (t2 > FILT_TOP) t2 = FILT_TOP;
      y = t1 + t2;
      if (y > FILT_TOP) y = FILT_TOP;
      filt_acc = y[FILT_W-1:0];
      last_rect = x[LEVEL_W-1:0];
    end
    env = (64'(filt_acc) + (64'd1 << (ENV_SHIFT - 1))) >> ENV_SHIFT;
    w.envelope = (env > LEVEL_TOP) ? LEVEL_TOP[LEVEL_W-1:0] : env[LEVEL_W-1:0];
    w.baseline = base_lvl;
    w.baseline_valid = base_ok;
  endtask

  always @(posedge clk) begin : watch
    env_word_t want, got;
    if (rst) begin
      regs.calib_count = CALIB_COUNT_RST;
      regs.feedback_coef = FEEDBACK_COEF_RST;
      regs.input_coef = INPUT_COEF_RST;
      cal_sum = '0;
      cal_seen = '0;
      base_lvl = '0;
      base_ok = 1'b0;
      filt_acc = '0;
      last_rect = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_CALIB_COUNT:   regs.calib_count = pwdata[CNT_W-1:0];
          ADDR_FEEDBACK_COEF: regs.feedback_coef = pwdata[COEF_W-1:0];
          ADDR_INPUT_COEF:    regs.input_coef = pwdata[COEF_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        step_envelope(s_tuser[0], s_tdata[SAMPLE_BITS-1:0], want);
        expected_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.envelope = m_tdata[LEVEL_W-1:0];
        got.baseline = m_tdata[2*LEVEL_W-1:LEVEL_W];
        got.baseline_valid = m_tdata[2*LEVEL_W];
        got.calib_done = m_tdata[2*LEVEL_W+1];
        if (expected_q.size() == 0) begin
          $error("unexpected word: envelope %0d baseline %0d", got.envelope, got.baseline);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.envelope !== want.envelope) begin
            $error("envelope: expected %0d, got %0d", want.envelope, got.envelope);
            fail_count++;
          end
          if (got.baseline !== want.baseline) begin
            $error("baseline: expected %0d, got %0d", want.baseline, got.baseline);
            fail_count++;
          end
          if (got.baseline_valid !== want.baseline_valid) begin
            $error("baseline_valid: expected %0d, got %0d",
                   want.baseline_valid, got.baseline_valid);
            fail_count++;
          end
          if (got.calib_done !== want.calib_done) begin
            $error("calib_done: expected %0d, got %0d", want.calib_done, got.calib_done);
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_q.size();
  end

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Top of the EMG envelope testbench: clock, reset, stimulus, register writes and verdict.
module tb_top;
  import ecal_pkg::*;

  localparam int SMP_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int SEG_WORDS = 185;
  localparam int LIMIT     = 800000;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 4'hC;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [9:0] sample, rest zero
  logic [0:0]            s_tuser;   // [0] cmd
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [17:0] envelope, [35:18] baseline,
                                    // [36] baseline_valid, [37] calib_done
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int cycles;
  int send_gap_pct;
  int take_gap_pct;
  int words_out;
  int hold_left;
  logic hold_done;

  emg_envelope_with_baseline_calib u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ecal_envelope_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) words_out <= words_out + 1;
  end

  // hold off the output once for a long stretch so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_out >= 60) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  task automatic send_word(input logic kind, input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= IN_DATA_W'(smp);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain the block before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int center);
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = SMP_MAX;
      2, 3, 4, 5: v = center + int'($urandom_range(40)) - 20;
      default: v = int'($urandom_range(SMP_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > SMP_MAX) v = SMP_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  initial begin : stimulus
    int seg, sent, blk, len, center;
    logic [CNT_W-1:0] cnt;
    logic [COEF_W-1:0] fb, ic;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    words_out = 0;
    hold_left = 0;
    hold_done = 1'b0;
    send_gap_pct = 36;
    take_gap_pct = 49;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // run before any baseline, then partial calibration at the reset count
    send_word(KIND_RUN, '0);
    send_word(KIND_RUN, SMP_MAX[SAMPLE_BITS-1:0]);
    send_word(KIND_RUN, 10'd512);
    send_word(KIND_CALIB, SMP_MAX[SAMPLE_BITS-1:0]);
    send_word(KIND_CALIB, '0);
    settle();
    apb_write(ADDR_CALIB_COUNT, APB_DATA_W'(16'hFFFF));
    apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_word(KIND_CALIB, 10'd700);
    // lower the count below what was already taken
    settle();
    apb_write(ADDR_CALIB_COUNT, APB_DATA_W'(16'd2));
    send_word(KIND_CALIB, 10'd5);
    settle();
    apb_write(ADDR_CALIB_COUNT, '0);
    send_word(KIND_CALIB, SMP_MAX[SAMPLE_BITS-1:0]);
    send_word(KIND_RUN, '0);
    send_word(KIND_RUN, SMP_MAX[SAMPLE_BITS-1:0]);
    // coefficients summing past one saturate the filter
    settle();
    apb_write(ADDR_FEEDBACK_COEF, APB_DATA_W'(24'hFFFFFF));
    apb_write(ADDR_INPUT_COEF, APB_DATA_W'(24'hFFFFFF));
    apb_write(ADDR_CALIB_COUNT, APB_DATA_W'(16'd1));
    send_word(KIND_CALIB, '0);
    repeat (3) send_word(KIND_RUN, SMP_MAX[SAMPLE_BITS-1:0]);
    settle();
    apb_write(ADDR_FEEDBACK_COEF, '0);
    apb_write(ADDR_INPUT_COEF, '0);
    send_word(KIND_RUN, SMP_MAX[SAMPLE_BITS-1:0]);
    send_word(KIND_RUN, '0);
    settle();
    apb_write(ADDR_FEEDBACK_COEF, APB_DATA_W'(FEEDBACK_COEF_RST));
    apb_write(ADDR_INPUT_COEF, APB_DATA_W'(24'h400000));
    apb_write(ADDR_CALIB_COUNT, APB_DATA_W'(16'd3));
    send_word(KIND_CALIB, 10'd100);
    send_word(KIND_CALIB, 10'd200);
    send_word(KIND_CALIB, 10'd301);
    send_word(KIND_RUN, 10'd200);
    send_word(KIND_RUN, 10'd199);
    send_word(KIND_RUN, 10'd201);

    for (seg = 0; seg < 6; seg++) begin
      settle();
      case (seg / 2)
        0: begin
          send_gap_pct = 36;
          take_gap_pct = 49;
        end
        1: begin
          send_gap_pct = 49;
          take_gap_pct = 36;
        end
        default: begin
          send_gap_pct = 0;
          take_gap_pct = 0;
        end
      endcase
      case ($urandom_range(5))
        0: cnt = '0;
        1: cnt = 16'd1;
        2: cnt = 16'd40;
        default: cnt = CNT_W'($urandom_range(2, 10));
      endcase
      case ($urandom_range(3))
        0: fb = FEEDBACK_COEF_RST;
        1: fb = COEF_W'($urandom);
        2: fb = 24'hFFFFFF;
        default: fb = 24'h800000;
      endcase
      case ($urandom_range(3))
        0: ic = INPUT_COEF_RST;
        1: ic = COEF_W'($urandom);
        2: ic = COEF_W'($urandom_range(24'h0FFFFF));
        default: ic = '0;
      endcase
      apb_write(ADDR_CALIB_COUNT, APB_DATA_W'(cnt));
      apb_write(ADDR_FEEDBACK_COEF, APB_DATA_W'(fb));
      apb_write(ADDR_INPUT_COEF, APB_DATA_W'(ic));
      len = (cnt == '0) ? 1 : int'(cnt);
      sent = 0;
      while (sent < SEG_WORDS) begin
        if ($urandom_range(99) < 70) begin
          center = int'($urandom_range(SMP_MAX));
          for (blk = 0; blk < len; blk++) send_word(KIND_CALIB, pick_sample(center));
          sent += len;
          blk = int'($urandom_range(4, 20));
          repeat (blk) send_word(KIND_RUN, pick_sample(center));
          sent += blk;
        end else begin
          send_word(1'($urandom), SAMPLE_BITS'($urandom));
          sent++;
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ecal_pkg.sv
rtl/core/ecal_regs.sv
rtl/core/ecal_div.sv
rtl/core/ecal_dp.sv
rtl/core/ecal_ctrl.sv
rtl/core/emg_envelope_with_baseline_calib.sv
verif/ecal_envelope_checker.sv
verif/tb_top.sv
